// ===== src/richardson_lucy_bg_em_terms_assert.svh =====
// Assertion macros shared by the RTL modules of the background EM terms block.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef RICHARDSON_LUCY_BG_EM_TERMS_ASSERT_SVH
`define RICHARDSON_LUCY_BG_EM_TERMS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RLBG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RLBG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rlbg_pkg.sv =====
// Shared types and constants of the background EM terms block.
// No dependencies; used by rlbg_div and richardson_lucy_bg_em_terms.
package rlbg_pkg;

  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_LOAD_RESP = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_DET  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_SKY  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COMPUTE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_M    = 3'd4;

  localparam int RES_W = 48;
  localparam int ACC_W = 64;
  localparam int QUO_W = 48;

  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

endpackage

// ===== src/rlbg_div.sv =====
// Restoring divider for ratio = floor(count * 2^56 / den), one quotient bit per cycle.
// Depends on rlbg_pkg.
module rlbg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [15:0]                count,
  input  logic [rlbg_pkg::ACC_W-1:0] den,
  output rlbg_pkg::div_stat_t        stat,
  output logic [rlbg_pkg::QUO_W-1:0] quo
);
  import rlbg_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic             sat_r;
  logic [5:0]       cnt_r;
  logic [ACC_W:0]   rem_r;
  logic [ACC_W-1:0] den_r;
  logic [QUO_W-1:0] q_r;
  logic [ACC_W-1:0] pre;
  logic [ACC_W:0]   rem2;
  logic             ge;

  assign pre  = {{(ACC_W-24){1'b0}}, count, 8'b0};
  assign rem2 = {rem_r[ACC_W-1:0], 1'b0};
  assign ge   = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if ((den == '0) || (pre >= den)) begin
          done_r <= 1'b1;
          sat_r  <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          sat_r  <= 1'b0;
          cnt_r  <= '0;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= {1'b0, pre};
      q_r   <= '1;
      if (!((den == '0) || (pre >= den))) begin
        q_r <= '0;
      end
    end else if (busy_r) begin
      rem_r <= ge ? (rem2 - {1'b0, den_r}) : rem2;
      q_r   <= {q_r[QUO_W-2:0], ge};
    end
  end

  assign stat.done = done_r;
  assign stat.sat  = sat_r;
  assign quo       = q_r;

endmodule

// ===== src/richardson_lucy_bg_em_terms.sv =====
// Top level of the Richardson-Lucy update terms block with a background component.
// Depends on rlbg_pkg, rlbg_div and richardson_lucy_bg_em_terms_assert.svh.
//
//  Channel  Ports                                     Transaction
//  input    start, busy, in_*                         start high while busy low
//  result   out_valid, out_result_value, out_sat...   one cycle strobe, no stall
//  config   cfg_we, cfg_index, cfg_data               write while cfg_we high
//
// Load and read transactions do not raise busy; their result is strobed the next cycle.
// A compute uses the shared multiplier and shifter once per product and the bit-serial
// divider once per detector.
// Reset clears control state only; the m store is tracked by a fill count, so no clear pass.
// The result side cannot stall; busy stays high for the whole compute.
`include "richardson_lucy_bg_em_terms_assert.svh"

module richardson_lucy_bg_em_terms #(
  parameter int MAX_DET = 256,
  parameter int MAX_SKY = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [rlbg_pkg::CMD_W-1:0] in_cmd,
  input  logic [7:0]                 in_det_index,
  input  logic [9:0]                 in_sky_index,
  input  logic [16:0]                in_resp_value,
  input  logic [15:0]                in_count_value,
  input  logic [31:0]                in_bg_value,
  input  logic [31:0]                in_rho_value,
  input  logic [31:0]                in_nu_value,
  output logic                       out_valid,
  output logic [rlbg_pkg::RES_W-1:0] out_result_value,
  output logic                       out_saturated,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [10:0]                cfg_data
);
  import rlbg_pkg::*;

  localparam int DW     = (MAX_DET > 1) ? $clog2(MAX_DET) : 1;
  localparam int SW     = (MAX_SKY > 1) ? $clog2(MAX_SKY) : 1;
  localparam int DCW    = $clog2(MAX_DET + 1);
  localparam int SCW    = $clog2(MAX_SKY + 1);
  localparam int RDEPTH = MAX_DET * MAX_SKY;
  localparam int RAW    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;

  localparam logic REG_DET_COUNT = 1'b0;
  localparam logic REG_SKY_COUNT = 1'b1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_OPL  = 3'd2;
  localparam logic [2:0] S_MLO  = 3'd3;
  localparam logic [2:0] S_MHI  = 3'd4;
  localparam logic [2:0] S_SHF  = 3'd5;
  localparam logic [2:0] S_ACC  = 3'd6;
  localparam logic [2:0] S_DIV  = 3'd7;

  localparam logic [2:0] K_P1A = 3'd0;
  localparam logic [2:0] K_P1B = 3'd1;
  localparam logic [2:0] K_P2A = 3'd2;
  localparam logic [2:0] K_P2B = 3'd3;
  localparam logic [2:0] K_P3A = 3'd4;
  localparam logic [2:0] K_P3B = 3'd5;

  logic [8:0]       det_count_r;
  logic [10:0]      sky_count_r;
  logic [2:0]       st_r, st_nxt;
  logic [2:0]       kind_r, kind_nxt;
  logic [DCW-1:0]   d_r, d_nxt, nd_r, nd_c;
  logic [SCW-1:0]   s_r, s_nxt, ns_r, ns_c, hw_r;
  logic [31:0]      nu_r;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             flag_r, flag_nxt;
  logic             rsat_r, rsat_nxt;
  logic [31:0]      a_r;
  logic [ACC_W-1:0] b_r;
  logic [63:0]      plo_r;
  logic [95:0]      prod_r;
  logic [ACC_W-1:0] mres_r;
  logic             msat_r;
  logic             out_valid_r;
  logic             out_sel_r;
  logic [RES_W-1:0] out_val_r;
  logic             out_sat_r;

  logic             accept;
  logic             last_d, last_s;
  logic [DCW-1:0]   nd_v;
  logic [SCW-1:0]   ns_v;
  logic [31:0]      mul_b;
  logic [63:0]      mul_p;
  logic [6:0]       sh_amt;
  logic             lim48;
  logic [95:0]      shp;
  logic             over;
  logic [ACC_W:0]   sum;
  logic [ACC_W-1:0] accv;
  logic             asat;
  logic             div_start;
  div_stat_t        div_st;
  logic [QUO_W-1:0] div_q;

  logic [16:0]      resp_mem [RDEPTH];
  logic [15:0]      count_mem [MAX_DET];
  logic [31:0]      bg_mem [MAX_DET];
  logic [31:0]      sky_mem [MAX_SKY];
  logic [QUO_W-1:0] ratio_mem [MAX_DET];
  logic [RES_W:0]   m_mem [MAX_SKY];
  logic [16:0]      resp_q;
  logic [15:0]      count_q;
  logic [31:0]      bg_q;
  logic [31:0]      sky_q;
  logic [QUO_W-1:0] ratio_q;
  logic [RES_W:0]   m_q;

  logic             rd_en;
  logic             det_ok, sky_ok;
  logic [RAW-1:0]   resp_waddr, resp_raddr;
  logic             m_we;

  assign busy   = st_r != S_IDLE;
  assign accept = start && !busy;
  assign det_ok = 32'(in_det_index) < MAX_DET;
  assign sky_ok = 32'(in_sky_index) < MAX_SKY;
  assign rd_en  = st_r == S_RD;

  assign nd_c = (32'(det_count_r) > MAX_DET) ? DCW'(MAX_DET) : DCW'(det_count_r);
  assign ns_c = (32'(sky_count_r) > MAX_SKY) ? SCW'(MAX_SKY) : SCW'(sky_count_r);
  assign nd_v = (st_r == S_IDLE) ? nd_c : nd_r;
  assign ns_v = (st_r == S_IDLE) ? ns_c : ns_r;
  assign last_d = d_r == (nd_r - DCW'(1));
  assign last_s = s_r == (ns_r - SCW'(1));

  assign resp_waddr = RAW'(RAW'(DW'(in_det_index)) * RAW'(MAX_SKY)) + RAW'(SW'(in_sky_index));
  assign resp_raddr = RAW'(RAW'(d_r[DW-1:0]) * RAW'(MAX_SKY)) + RAW'(s_r[SW-1:0]);

  always_ff @(posedge clk) begin
    if (accept && (in_cmd == CMD_LOAD_RESP) && det_ok && sky_ok) begin
      resp_mem[resp_waddr] <= in_resp_value;
    end
    if (rd_en) begin
      resp_q <= resp_mem[resp_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_cmd == CMD_LOAD_DET) && det_ok) begin
      count_mem[DW'(in_det_index)] <= in_count_value;
      bg_mem[DW'(in_det_index)]    <= in_bg_value;
    end
    if (rd_en) begin
      count_q <= count_mem[d_r[DW-1:0]];
      bg_q    <= bg_mem[d_r[DW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_cmd == CMD_LOAD_SKY) && sky_ok) begin
      sky_mem[SW'(in_sky_index)] <= in_rho_value;
    end
    if (rd_en) begin
      sky_q <= sky_mem[s_r[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if ((st_r == S_DIV) && div_st.done) begin
      ratio_mem[d_r[DW-1:0]] <= div_q;
    end
    if (rd_en) begin
      ratio_q <= ratio_mem[d_r[DW-1:0]];
    end
  end

  assign m_we = (st_r == S_ACC) && (kind_r == K_P2B);

  always_ff @(posedge clk) begin
    if (m_we) begin
      m_mem[s_r[SW-1:0]] <= {flag_r | msat_r, mres_r[RES_W-1:0]};
    end
    if (accept && (in_cmd == CMD_READ_M)) begin
      m_q <= m_mem[SW'(in_sky_index)];
    end
  end

  assign mul_b = (st_r == S_MLO) ? b_r[31:0] : b_r[63:32];
  assign mul_p = a_r * mul_b;

  always_comb begin
    sh_amt = 7'd15;
    lim48  = 1'b0;
    case (kind_r)
      K_P2A: sh_amt = 7'd16;
      K_P2B: begin
        sh_amt = 7'd23;
        lim48  = 1'b1;
      end
      K_P3A: sh_amt = 7'd8;
      K_P3B: begin
        sh_amt = 7'd31;
        lim48  = 1'b1;
      end
      default: sh_amt = 7'd15;
    endcase
  end

  assign shp  = prod_r >> sh_amt;
  assign over = (|shp[95:64]) || (lim48 && (|shp[63:48]));
  assign sum  = {1'b0, acc_r} + {1'b0, mres_r};
  assign asat = sum[ACC_W];
  assign accv = asat ? '1 : sum[ACC_W-1:0];

  assign div_start = (st_r == S_ACC) && (kind_r == K_P1B);

  rlbg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .count (count_q),
    .den   (accv),
    .stat  (div_st),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    case (st_r)
      S_OPL: begin
        case (kind_r)
          K_P1A: begin
            a_r <= {15'b0, resp_q};
            b_r <= {32'b0, sky_q};
          end
          K_P1B: begin
            a_r <= nu_r;
            b_r <= {32'b0, bg_q};
          end
          K_P2A: begin
            a_r <= {15'b0, resp_q};
            b_r <= {16'b0, ratio_q};
          end
          K_P2B: begin
            a_r <= sky_q;
            b_r <= acc_r;
          end
          K_P3A: begin
            a_r <= bg_q;
            b_r <= {16'b0, ratio_q};
          end
          default: begin
            a_r <= nu_r;
            b_r <= acc_r;
          end
        endcase
      end
      S_MLO: plo_r <= mul_p;
      S_MHI: prod_r <= {32'b0, plo_r} + {mul_p, 32'b0};
      S_SHF: begin
        msat_r <= over;
        if (over) begin
          mres_r <= lim48 ? {16'b0, {RES_W{1'b1}}} : '1;
        end else begin
          mres_r <= shp[63:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st_nxt   = st_r;
    kind_nxt = kind_r;
    d_nxt    = d_r;
    s_nxt    = s_r;
    acc_nxt  = acc_r;
    flag_nxt = flag_r;
    rsat_nxt = rsat_r;
    unique case (st_r)
      S_IDLE: begin
        if (accept && (in_cmd == CMD_COMPUTE)) begin
          rsat_nxt = 1'b0;
          st_nxt   = S_RD;
          d_nxt    = '0;
          s_nxt    = '0;
          acc_nxt  = '0;
          flag_nxt = 1'b0;
          if (nd_v != '0) begin
            kind_nxt = (ns_v != '0) ? K_P1A : K_P1B;
          end else if (ns_v != '0) begin
            kind_nxt = K_P2B;
          end else begin
            kind_nxt = K_P3B;
          end
        end
      end
      S_RD:  st_nxt = S_OPL;
      S_OPL: st_nxt = S_MLO;
      S_MLO: st_nxt = S_MHI;
      S_MHI: st_nxt = S_SHF;
      S_SHF: st_nxt = S_ACC;
      S_ACC: begin
        st_nxt = S_RD;
        case (kind_r)
          K_P1A: begin
            acc_nxt = accv;
            if (last_s) begin
              kind_nxt = K_P1B;
            end else begin
              s_nxt = s_r + SCW'(1);
            end
          end
          K_P1B: begin
            acc_nxt = accv;
            st_nxt  = S_DIV;
          end
          K_P2A: begin
            acc_nxt  = accv;
            flag_nxt = flag_r | msat_r | asat;
            if (last_d) begin
              kind_nxt = K_P2B;
            end else begin
              d_nxt = d_r + DCW'(1);
            end
          end
          K_P2B: begin
            d_nxt    = '0;
            acc_nxt  = '0;
            flag_nxt = rsat_r;
            if (last_s) begin
              kind_nxt = (nd_r != '0) ? K_P3A : K_P3B;
            end else begin
              s_nxt    = s_r + SCW'(1);
              kind_nxt = (nd_r != '0) ? K_P2A : K_P2B;
            end
          end
          K_P3A: begin
            acc_nxt  = accv;
            flag_nxt = flag_r | msat_r | asat;
            if (last_d) begin
              kind_nxt = K_P3B;
            end else begin
              d_nxt = d_r + DCW'(1);
            end
          end
          default: st_nxt = S_IDLE;
        endcase
      end
      S_DIV: begin
        if (div_st.done) begin
          rsat_nxt = rsat_r | div_st.sat;
          st_nxt   = S_RD;
          s_nxt    = '0;
          acc_nxt  = '0;
          if (!last_d) begin
            d_nxt    = d_r + DCW'(1);
            kind_nxt = (ns_r != '0) ? K_P1A : K_P1B;
          end else begin
            d_nxt    = '0;
            flag_nxt = rsat_r | div_st.sat;
            if (ns_r != '0) begin
              kind_nxt = K_P2A;
            end else begin
              kind_nxt = K_P3A;
            end
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      kind_r      <= K_P1A;
      d_r         <= '0;
      s_r         <= '0;
      nd_r        <= '0;
      ns_r        <= '0;
      flag_r      <= 1'b0;
      rsat_r      <= 1'b0;
      hw_r        <= '0;
      det_count_r <= 9'd256;
      sky_count_r <= 11'd1024;
      out_valid_r <= 1'b0;
      out_sel_r   <= 1'b0;
      out_sat_r   <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      kind_r      <= kind_nxt;
      d_r         <= d_nxt;
      s_r         <= s_nxt;
      flag_r      <= flag_nxt;
      rsat_r      <= rsat_nxt;
      out_valid_r <= 1'b0;
      out_sel_r   <= 1'b0;
      out_sat_r   <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DET_COUNT: det_count_r <= cfg_data[8:0];
          REG_SKY_COUNT: sky_count_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        out_valid_r <= (in_cmd != CMD_COMPUTE);
        out_sel_r   <= (in_cmd == CMD_READ_M) && sky_ok && (SCW'(in_sky_index) < hw_r);
        if (in_cmd == CMD_COMPUTE) begin
          nd_r <= nd_c;
          ns_r <= ns_c;
        end
      end
      if (m_we && ((s_r + SCW'(1)) > hw_r)) begin
        hw_r <= s_r + SCW'(1);
      end
      if ((st_r == S_ACC) && (kind_r == K_P3B)) begin
        out_valid_r <= 1'b1;
        out_sat_r   <= flag_r | msat_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (accept && (in_cmd == CMD_COMPUTE)) begin
      nu_r <= in_nu_value;
    end
    if ((st_r == S_ACC) && (kind_r == K_P3B)) begin
      out_val_r <= mres_r[RES_W-1:0];
    end else if (accept) begin
      out_val_r <= '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_sel_r ? m_q[RES_W-1:0] : out_val_r;
  assign out_saturated    = out_sel_r ? m_q[RES_W] : out_sat_r;

  `RLBG_ASSERT_IMP(a_no_result_while_busy, busy, !out_valid, "result strobed during compute")
  `RLBG_ASSERT_NEXT(a_compute_goes_busy, accept && (in_cmd == CMD_COMPUTE), busy, "compute not started")
  `RLBG_ASSERT_NEXT(a_short_cmd_result, accept && (in_cmd != CMD_COMPUTE), out_valid, "missing result")
  `RLBG_ASSERT_IMP(a_div_done_in_wait, div_st.done, st_r == S_DIV, "divider finished outside wait")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for richardson_lucy_bg_em_terms: directed and random
// loads, computes and m reads, checked against a behavioral predictor held here.
// Depends on rlbg_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module testbench;
  import rlbg_pkg::*;

  localparam int NDET = 256;
  localparam int NSKY = 1024;
  localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] SAT64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [2:0] CMD_BOGUS = 3'd7;
  localparam logic CFG_DET = 1'b0;
  localparam logic CFG_SKY = 1'b1;
  localparam int IDLE_LIMIT = 200000;

  typedef struct {
    logic [47:0] value;
    logic        sat;
  } term_t;

  logic clk, rst_n, start, busy;
  logic [CMD_W-1:0] in_cmd;
  logic [7:0] in_det_index;
  logic [9:0] in_sky_index;
  logic [16:0] in_resp_value;
  logic [15:0] in_count_value;
  logic [31:0] in_bg_value, in_rho_value, in_nu_value;
  logic out_valid, out_saturated;
  logic [RES_W-1:0] out_result_value;
  logic cfg_we, cfg_index;
  logic [10:0] cfg_data;

  richardson_lucy_bg_em_terms dut (.*);

  // Predictor state.
  bit [16:0] resp_mem [0:NDET*NSKY-1];
  bit        resp_wr  [0:NDET*NSKY-1];
  bit [15:0] count_mem [0:NDET-1];
  bit [31:0] bg_mem    [0:NDET-1];
  bit        det_wr    [0:NDET-1];
  bit [31:0] rho_mem   [0:NSKY-1];
  bit        sky_wr    [0:NSKY-1];
  bit [47:0] ratio_mem [0:NDET-1];
  bit [47:0] m_mem     [0:NSKY-1];
  bit        m_sat     [0:NSKY-1];
  bit        m_wr      [0:NSKY-1];
  int unsigned det_used, sky_used;

  term_t expected_terms[$];
  int errors, items, computes, reads, burst_left, idle_cycles;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] mul_trunc(logic [63:0] a, logic [63:0] b, int sh,
                                            logic [63:0] lim, inout bit sat);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> sh;
    if (p > {64'b0, lim}) begin
      sat = 1;
      return lim;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] acc_add(logic [63:0] a, logic [63:0] b, inout bit sat);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64]) begin
      sat = 1;
      return SAT64;
    end
    return s[63:0];
  endfunction

  function automatic term_t predict_update(logic [31:0] nu);
    int unsigned nd, ns;
    bit ratio_sat, junk, ms, n_sat;
    logic [63:0] den, t, dot, n;
    logic [127:0] num;
    term_t r;
    nd = det_used > NDET ? NDET : det_used;
    ns = sky_used > NSKY ? NSKY : sky_used;
    ratio_sat = 0;
    junk = 0;
    for (int d = 0; d < nd; d++) begin
      den = 0;
      for (int s = 0; s < ns; s++)
        den = acc_add(den, mul_trunc(resp_mem[d*NSKY+s], rho_mem[s], 15, SAT64, junk), junk);
      den = acc_add(den, mul_trunc(nu, bg_mem[d], 15, SAT64, junk), junk);
      num = {112'b0, count_mem[d]} << 56;
      if (den == 0 || ({56'b0, count_mem[d], 8'b0} >= {64'b0, den})) begin
        ratio_sat = 1;
        ratio_mem[d] = SAT48;
      end else begin
        num = num / {64'b0, den};
        ratio_mem[d] = num[47:0];
      end
    end
    for (int s = 0; s < ns; s++) begin
      ms = ratio_sat;
      t = 0;
      for (int d = 0; d < nd; d++)
        t = acc_add(t, mul_trunc(resp_mem[d*NSKY+s], ratio_mem[d], 16, SAT64, ms), ms);
      m_mem[s] = mul_trunc(rho_mem[s], t, 23, {16'b0, SAT48}, ms);
      m_sat[s] = ms;
      m_wr[s] = 1;
    end
    n_sat = ratio_sat;
    dot = 0;
    for (int d = 0; d < nd; d++)
      dot = acc_add(dot, mul_trunc(ratio_mem[d], bg_mem[d], 8, SAT64, n_sat), n_sat);
    n = mul_trunc(nu, dot, 31, {16'b0, SAT48}, n_sat);
    r.value = n[47:0];
    r.sat = n_sat;
    return r;
  endfunction

  function automatic term_t predict_step(logic [2:0] cmd, logic [7:0] di, logic [9:0] si,
                                         logic [16:0] rv, logic [15:0] cv, logic [31:0] bv,
                                         logic [31:0] pv, logic [31:0] nv);
    term_t r;
    r.value = 0;
    r.sat = 0;
    case (cmd)
      CMD_LOAD_RESP: begin
        resp_mem[{di, si}] = rv;
        resp_wr[{di, si}] = 1;
      end
      CMD_LOAD_DET: begin
        count_mem[di] = cv;
        bg_mem[di] = bv;
        det_wr[di] = 1;
      end
      CMD_LOAD_SKY: begin
        rho_mem[si] = pv;
        sky_wr[si] = 1;
      end
      CMD_COMPUTE: r = predict_update(nv);
      CMD_READ_M: begin
        r.value = m_mem[si];
        r.sat = m_sat[si];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(logic [2:0] cmd, logic [7:0] di, logic [9:0] si,
                           logic [16:0] rv, logic [15:0] cv, logic [31:0] bv,
                           logic [31:0] pv, logic [31:0] nv);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    repeat (gap) begin
      @(negedge clk);
      start = 0;
      in_cmd = $urandom;
    end
    @(negedge clk);
    while (busy) begin
      start = 0;
      @(negedge clk);
    end
    start = 1;
    in_cmd = cmd;
    in_det_index = di;
    in_sky_index = si;
    in_resp_value = rv;
    in_count_value = cv;
    in_bg_value = bv;
    in_rho_value = pv;
    in_nu_value = nv;
    expected_terms.push_back(predict_step(cmd, di, si, rv, cv, bv, pv, nv));
    items++;
    if (cmd == CMD_COMPUTE) computes++;
    if (cmd == CMD_READ_M) reads++;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 0;
    while (expected_terms.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [10:0] value);
    drain();
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = value;
    if (idx == CFG_DET) det_used = value[8:0];
    else sky_used = value;
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic logic [16:0] rand_resp();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd65536;
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  function automatic logic [31:0] rand_frac();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'h8000_0000;
      default: return $urandom_range(0, 32'h8000_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_bg();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h000F_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_count();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return $urandom_range(0, 64);
      default: return $urandom;
    endcase
  endfunction

  // Writes every entry the next compute will read that was never loaded.
  task automatic fill_used_region();
    for (int d = 0; d < det_used; d++) begin
      if (!det_wr[d]) send_item(CMD_LOAD_DET, d, 0, 0, rand_count(), rand_bg(), 0, 0);
      for (int s = 0; s < sky_used; s++)
        if (!resp_wr[d*NSKY+s]) send_item(CMD_LOAD_RESP, d, s, rand_resp(), 0, 0, 0, 0);
    end
    for (int s = 0; s < sky_used; s++)
      if (!sky_wr[s]) send_item(CMD_LOAD_SKY, 0, s, 0, 0, 0, rand_frac(), 0);
  endtask

  task automatic read_written_m();
    int s;
    for (int k = 0; k < 16; k++) begin
      s = $urandom_range(0, NSKY-1);
      if (m_wr[s]) break;
    end
    if (!m_wr[s]) for (s = 0; s < NSKY-1 && !m_wr[s]; s++) ;
    if (m_wr[s]) send_item(CMD_READ_M, $urandom, s, $urandom, $urandom, $urandom, $urandom, 0);
  endtask

  task automatic test_directed();
    write_reg(CFG_DET, 2);
    write_reg(CFG_SKY, 3);
    for (int d = 0; d < 2; d++) begin
      send_item(CMD_LOAD_DET, d, 0, 0, 0, 0, 0, 0);
      for (int s = 0; s < 3; s++) send_item(CMD_LOAD_RESP, d, s, 17'd0, 0, 0, 0, 0);
    end
    for (int s = 0; s < 3; s++) send_item(CMD_LOAD_SKY, 0, s, 0, 0, 0, 32'd0, 0);
    // Zero denominator on every detector.
    send_item(CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 32'd0);
    send_item(CMD_READ_M, 0, 2, 0, 0, 0, 0, 0);
    send_item(CMD_LOAD_RESP, 1, 2, 17'd65536, 0, 0, 0, 0);
    send_item(CMD_LOAD_SKY, 0, 2, 0, 0, 0, 32'h8000_0000, 0);
    send_item(CMD_LOAD_DET, 0, 0, 0, 16'hFFFF, 32'hFFFF_FFFF, 0, 0);
    send_item(CMD_LOAD_DET, 1, 0, 0, 16'd5, 32'h0001_0000, 0, 0);
    send_item(CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 32'h8000_0000);
    send_item(CMD_READ_M, 0, 2, 0, 0, 0, 0, 0);
    send_item(CMD_LOAD_DET, 255, 0, 0, 16'd1, 32'd1, 0, 0);
    send_item(CMD_LOAD_SKY, 0, 1023, 0, 0, 0, 32'hFFFF_FFFF, 0);
    send_item(CMD_LOAD_RESP, 255, 1023, 17'h1FFFF, 0, 0, 0, 0);
    send_item(CMD_BOGUS, 255, 1023, 17'h1FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_item(3'd5, 0, 0, 0, 0, 0, 0, 0);
    send_item(CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_DET, 0);
    write_reg(CFG_SKY, 0);
    send_item(CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 32'h4000_0000);
    write_reg(CFG_DET, 9'h1FF);
    write_reg(CFG_SKY, 11'h7FF);
    send_item(CMD_LOAD_RESP, 128, 512, rand_resp(), 0, 0, 0, 0);
    read_written_m();
    write_reg(CFG_DET, 256);
    write_reg(CFG_SKY, 1024);
    read_written_m();
    write_reg(CFG_DET, 1);
    write_reg(CFG_SKY, 1);
    fill_used_region();
    send_item(CMD_COMPUTE, 0, 0, 0, 0, 0, 0, rand_frac());
  endtask

  task automatic test_random_phases();
    int pick, op_count;
    while (items < 1450) begin
      if ($urandom_range(0, 9) == 0) begin
        write_reg(CFG_DET, $urandom_range(0, 12));
        write_reg(CFG_SKY, $urandom_range(0, 24));
      end else begin
        write_reg(CFG_DET, $urandom_range(1, 4));
        write_reg(CFG_SKY, $urandom_range(1, 8));
      end
      fill_used_region();
      op_count = $urandom_range(10, 40);
      repeat (op_count) begin
        pick = $urandom_range(0, 99);
        if (pick < 25)
          send_item(CMD_LOAD_RESP, $urandom_range(0, det_used), $urandom_range(0, sky_used),
                    rand_resp(), $urandom, $urandom, $urandom, $urandom);
        else if (pick < 40)
          send_item(CMD_LOAD_DET, $urandom_range(0, det_used), $urandom, $urandom,
                    rand_count(), rand_bg(), $urandom, $urandom);
        else if (pick < 52)
          send_item(CMD_LOAD_SKY, $urandom, $urandom_range(0, sky_used), $urandom, $urandom,
                    $urandom, rand_frac(), $urandom);
        else if (pick < 68)
          send_item(CMD_COMPUTE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    rand_frac());
        else if (pick < 94)
          read_written_m();
        else
          send_item($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    errors++;
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    term_t e;
    if (rst_n && out_valid) begin
      if (expected_terms.size() == 0) begin
        errors++;
        $display("%0t: result transaction with nothing expected", $realtime);
      end else begin
        e = expected_terms.pop_front();
        if (out_result_value !== e.value) report_mismatch("result_value", out_result_value,
                                                          e.value);
        if (out_saturated !== e.sat) report_mismatch("saturated", out_saturated, e.sat);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n = 0;
    start = 0;
    in_cmd = 0;
    in_det_index = 0;
    in_sky_index = 0;
    in_resp_value = 0;
    in_count_value = 0;
    in_bg_value = 0;
    in_rho_value = 0;
    in_nu_value = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    errors = 0;
    items = 0;
    computes = 0;
    reads = 0;
    burst_left = 0;
    idle_cycles = 0;
    det_used = 256;
    sky_used = 1024;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    test_register_extremes();
    test_random_phases();
    drain();
    $display("Sent %0d transactions: %0d computes and %0d m reads checked.",
             items, computes, reads);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/rlbg_pkg.sv
src/rlbg_div.sv
src/richardson_lucy_bg_em_terms.sv
verif/testbench.sv
